/* hw/rtl/sit_pkg.sv */
// shared types, relation codes and width helpers for the segment intersection test
package sit_pkg;

	localparam int IN_W  = 16;
	localparam int OUT_W = 24;

	// relation codes
	localparam logic [1:0] REL_CROSS     = 2'd0;
	localparam logic [1:0] REL_MISS      = 2'd1;
	localparam logic [1:0] REL_PARALLEL  = 2'd2;
	localparam logic [1:0] REL_COLLINEAR = 2'd3;

	typedef struct packed {
		logic signed [IN_W-1:0] a_start_x;
		logic signed [IN_W-1:0] a_start_y;
		logic signed [IN_W-1:0] a_end_x;
		logic signed [IN_W-1:0] a_end_y;
		logic signed [IN_W-1:0] b_start_x;
		logic signed [IN_W-1:0] b_start_y;
		logic signed [IN_W-1:0] b_end_x;
		logic signed [IN_W-1:0] b_end_y;
	} item_t;

	typedef struct packed {
		logic                    hit;
		logic [1:0]              relation;
		logic signed [OUT_W-1:0] cross_x;
		logic signed [OUT_W-1:0] cross_y;
	} result_t;

	// coordinate width after masking: wider settings see the field as unsigned
	function automatic int coord_w(input int cb);
		return (cb <= IN_W) ? cb : IN_W + 1;
	endfunction

	function automatic int diff_w(input int cb);
		return coord_w(cb) + 1;
	endfunction

	function automatic int cross_w(input int cb);
		return 2 * diff_w(cb);
	endfunction

	// hit, relation, px, py, rx, ry, tn, den
	function automatic int mid_w(input int cb);
		return 3 + 2 * coord_w(cb) + 2 * diff_w(cb) + 2 * cross_w(cb);
	endfunction

endpackage

/* hw/rtl/segment_intersection_test.sv */
// top level of the 2d segment intersection test
//
// usage
//  - input channel: drive item with two segments (a from start to end, b likewise)
//    and raise push; a transfer happens at a clock edge with push high and full low
//  - result channel: while empty is low the oldest result sits on result; a transfer
//    happens at a clock edge with pop high and empty low
//  - one result per item, in item order: hit, relation code, and the crossing point
//    in fixed point with FRAC_BITS fraction bits (zero unless hit)
//  - throughput: one item per cycle sustained while the result side keeps popping
//  - the divider has QB stages, one quotient bit per stage, where QB is the
//    COORD_BITS-derived difference width + FRAC_BITS
//  - a four-entry queue between the classifier and the divider lets each side stall
//    on its own; a two-entry output queue decouples the result side
//  - when the receiver stalls, the divider pipeline freezes once the output queue is
//    full and its last stage holds a result, then the classifier fills the middle
//    queue, then full rises
//  - reset empties every queue and clears all valid flags; no payload is cleared
//  - no configuration registers and no clearing pass after reset
module segment_intersection_test import sit_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam int MW = mid_w(COORD_BITS);
	localparam int RW = $bits(result_t);

	// classifier to divider queue
	logic          mid_push, mid_full, mid_pop, mid_empty;
	logic [MW-1:0] mid_wdata, mid_rdata;

	// divider to result queue
	logic          out_push, out_full;
	result_t       out_wdata;
	logic [RW-1:0] out_rdata;

	sit_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_push (mid_push),
		.mid_full (mid_full),
		.mid_data (mid_wdata)
	);

	sit_fifo #(
		.WIDTH(MW),
		.DEPTH(4)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	sit_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_data  (mid_rdata),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_wdata)
	);

	// result queue; its flags come straight from registered occupancy
	sit_fifo #(
		.WIDTH(RW),
		.DEPTH(2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = result_t'(out_rdata);

endmodule

/* hw/rtl/sit_fifo.sv */
// small synchronous queue with registered occupancy flags
module sit_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not follow a lone pop");

endmodule

/* hw/rtl/sit_front.sv */
// front pipeline: differences, cross products and classification
module sit_front import sit_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  item_t                         item,
	output logic                          mid_push,
	input  logic                          mid_full,
	output logic [mid_w(COORD_BITS)-1:0]  mid_data
);

	localparam int CW = coord_w(COORD_BITS);
	localparam int DW = diff_w(COORD_BITS);
	localparam int XW = cross_w(COORD_BITS);

	typedef struct packed {
		logic                 hit;
		logic [1:0]           relation;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [DW-1:0] rx;
		logic signed [DW-1:0] ry;
		logic signed [XW-1:0] tn;
		logic signed [XW-1:0] den;
	} mid_t;

	function automatic logic signed [CW-1:0] sext(input logic [IN_W-1:0] v);
		logic [IN_W:0] ext;
		ext = {1'b0, v};
		return ext[CW-1:0];
	endfunction

	function automatic logic in_unit(input logic signed [XW-1:0] n,
		input logic signed [XW-1:0] d);
		if (!d[XW-1]) begin
			return !n[XW-1] && (n <= d);
		end
		return (n <= 0) && (n >= d);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	item_t item_s1;

	logic signed [CW-1:0] px_c, py_c, ax_c, ay_c, qx_c, qy_c, bx_c, by_c;
	logic signed [CW-1:0] px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic signed [DW-1:0] rx_s2, ry_s2, sx_s2, sy_s2, dx_s2, dy_s2;
	logic signed [DW-1:0] rx_s3, ry_s3, rx_s4, ry_s4;
	logic signed [XW-1:0] m_rs1_s3, m_rs2_s3, m_t1_s3, m_t2_s3, m_u1_s3, m_u2_s3;
	logic signed [XW-1:0] den_s4, tn_s4, un_s4;
	mid_t mid_c;

	assign en       = !(v_s4 && mid_full);
	assign full     = !en;
	assign mid_push = v_s4 && en;

	assign px_c = sext(item_s1.a_start_x);
	assign py_c = sext(item_s1.a_start_y);
	assign ax_c = sext(item_s1.a_end_x);
	assign ay_c = sext(item_s1.a_end_y);
	assign qx_c = sext(item_s1.b_start_x);
	assign qy_c = sext(item_s1.b_start_y);
	assign bx_c = sext(item_s1.b_end_x);
	assign by_c = sext(item_s1.b_end_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			// segment deltas
			px_s2 <= px_c;
			py_s2 <= py_c;
			rx_s2 <= DW'(ax_c) - DW'(px_c);
			ry_s2 <= DW'(ay_c) - DW'(py_c);
			sx_s2 <= DW'(bx_c) - DW'(qx_c);
			sy_s2 <= DW'(by_c) - DW'(qy_c);
			dx_s2 <= DW'(qx_c) - DW'(px_c);
			dy_s2 <= DW'(qy_c) - DW'(py_c);
			// partial products
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			rx_s3    <= rx_s2;
			ry_s3    <= ry_s2;
			m_rs1_s3 <= XW'(rx_s2) * XW'(sy_s2);
			m_rs2_s3 <= XW'(ry_s2) * XW'(sx_s2);
			m_t1_s3  <= XW'(dx_s2) * XW'(sy_s2);
			m_t2_s3  <= XW'(dy_s2) * XW'(sx_s2);
			m_u1_s3  <= XW'(dx_s2) * XW'(ry_s2);
			m_u2_s3  <= XW'(dy_s2) * XW'(rx_s2);
			// cross products
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			den_s4 <= m_rs1_s3 - m_rs2_s3;
			tn_s4  <= m_t1_s3 - m_t2_s3;
			un_s4  <= m_u1_s3 - m_u2_s3;
		end
	end

	always_comb begin
		mid_c     = '0;
		mid_c.px  = px_s4;
		mid_c.py  = py_s4;
		mid_c.rx  = rx_s4;
		mid_c.ry  = ry_s4;
		mid_c.tn  = tn_s4;
		mid_c.den = den_s4;
		if (den_s4 == '0) begin
			mid_c.relation = (un_s4 == '0) ? REL_COLLINEAR : REL_PARALLEL;
		end else if (in_unit(tn_s4, den_s4) && in_unit(un_s4, den_s4)) begin
			mid_c.hit      = 1'b1;
			mid_c.relation = REL_CROSS;
		end else begin
			mid_c.relation = REL_MISS;
		end
	end

	assign mid_data = mid_c;

endmodule

/* hw/rtl/sit_back.sv */
// back pipeline: scaled products, bit-per-stage division and point assembly
module sit_back import sit_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mid_empty,
	output logic                          mid_pop,
	input  logic [mid_w(COORD_BITS)-1:0]  mid_data,
	input  logic                          out_full,
	output logic                          out_push,
	output result_t                       out_data
);

	localparam int CW  = coord_w(COORD_BITS);
	localparam int DW  = diff_w(COORD_BITS);
	localparam int XW  = cross_w(COORD_BITS);
	localparam int PRW = DW + XW;
	localparam int QB  = DW + FRAC_BITS;
	localparam int NW  = XW + QB;
	localparam int AW0 = (CW + FRAC_BITS > QB) ? CW + FRAC_BITS : QB;
	localparam int AW  = (AW0 + 1 > OUT_W) ? AW0 + 1 : OUT_W;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           relation;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [DW-1:0] rx;
		logic signed [DW-1:0] ry;
		logic signed [XW-1:0] tn;
		logic signed [XW-1:0] den;
	} mid_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           relation;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic                 neg_x;
		logic                 neg_y;
		logic [XW-1:0]        den_mag;
	} side_t;

	logic en;
	logic v_s1, v_s2;
	mid_t mid_s1;
	side_t side_s2;
	logic [DW-1:0] mag_rx_s2, mag_ry_s2;
	logic [XW-1:0] mag_tn_s2;
	logic [PRW-1:0] prod_x, prod_y;
	logic [NW-1:0]  num_x, num_y;

	logic          div_v_s    [QB+1];
	side_t         div_side_s [QB+1];
	logic [XW-1:0] rem_x_s    [QB+1];
	logic [XW-1:0] rem_y_s    [QB+1];
	logic [QB-1:0] lo_x_s     [QB+1];
	logic [QB-1:0] lo_y_s     [QB+1];

	logic signed [AW-1:0] base_x, base_y, qx_w, qy_w, sum_x, sum_y;

	assign en       = !(div_v_s[QB] && out_full);
	assign mid_pop  = en && !mid_empty;
	assign out_push = div_v_s[QB] && en;

	assign prod_x = PRW'(mag_rx_s2) * PRW'(mag_tn_s2);
	assign prod_y = PRW'(mag_ry_s2) * PRW'(mag_tn_s2);
	assign num_x  = NW'(prod_x) << FRAC_BITS;
	assign num_y  = NW'(prod_y) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1       <= mid_pop;
			v_s2       <= v_s1;
			div_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1 <= mid_t'(mid_data);
			// magnitudes and quotient signs
			side_s2.hit      <= mid_s1.hit;
			side_s2.relation <= mid_s1.relation;
			side_s2.px       <= mid_s1.px;
			side_s2.py       <= mid_s1.py;
			side_s2.neg_x    <= mid_s1.rx[DW-1] ^ mid_s1.tn[XW-1] ^ mid_s1.den[XW-1];
			side_s2.neg_y    <= mid_s1.ry[DW-1] ^ mid_s1.tn[XW-1] ^ mid_s1.den[XW-1];
			side_s2.den_mag  <= mid_s1.den[XW-1] ? XW'(-mid_s1.den) : mid_s1.den;
			mag_rx_s2 <= mid_s1.rx[DW-1] ? DW'(-mid_s1.rx) : mid_s1.rx;
			mag_ry_s2 <= mid_s1.ry[DW-1] ? DW'(-mid_s1.ry) : mid_s1.ry;
			mag_tn_s2 <= mid_s1.tn[XW-1] ? XW'(-mid_s1.tn) : mid_s1.tn;
			// scaled dividend split into partial remainder and pending bits
			div_side_s[0] <= side_s2;
			rem_x_s[0]    <= num_x[NW-1:QB];
			rem_y_s[0]    <= num_y[NW-1:QB];
			lo_x_s[0]     <= num_x[QB-1:0];
			lo_y_s[0]     <= num_y[QB-1:0];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [XW:0] try_x, try_y;
		logic        ge_x, ge_y;

		assign try_x = {rem_x_s[k], lo_x_s[k][QB-1]};
		assign try_y = {rem_y_s[k], lo_y_s[k][QB-1]};
		assign ge_x  = try_x >= {1'b0, div_side_s[k].den_mag};
		assign ge_y  = try_y >= {1'b0, div_side_s[k].den_mag};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_side_s[k+1] <= div_side_s[k];
				rem_x_s[k+1] <= ge_x ? XW'(try_x - {1'b0, div_side_s[k].den_mag})
					: try_x[XW-1:0];
				rem_y_s[k+1] <= ge_y ? XW'(try_y - {1'b0, div_side_s[k].den_mag})
					: try_y[XW-1:0];
				lo_x_s[k+1] <= {lo_x_s[k][QB-2:0], ge_x};
				lo_y_s[k+1] <= {lo_y_s[k][QB-2:0], ge_y};
			end
		end
	end

	// p scaled plus the signed truncated quotient, wrapped to the field
	always_comb begin
		base_x = AW'(div_side_s[QB].px) <<< FRAC_BITS;
		base_y = AW'(div_side_s[QB].py) <<< FRAC_BITS;
		qx_w   = AW'(lo_x_s[QB]);
		qy_w   = AW'(lo_y_s[QB]);
		sum_x  = base_x + (div_side_s[QB].neg_x ? -qx_w : qx_w);
		sum_y  = base_y + (div_side_s[QB].neg_y ? -qy_w : qy_w);
		out_data.hit      = div_side_s[QB].hit;
		out_data.relation = div_side_s[QB].relation;
		out_data.cross_x  = div_side_s[QB].hit ? sum_x[OUT_W-1:0] : '0;
		out_data.cross_y  = div_side_s[QB].hit ? sum_y[OUT_W-1:0] : '0;
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !out_data.hit) |-> (out_data.cross_x == '0 && out_data.cross_y == '0))
		else $error("non-crossing result carries a point");

endmodule
